>>> sv/isort_pkg.sv
package isort_pkg;

    localparam int MAX_COUNT_DEF = 32;
    localparam int VALUE_W       = 32;
    localparam int MOVES_W       = 11;

    typedef enum logic [0:0] {
        ST_FILL,
        ST_DRAIN
    } isort_state_t;

    // Per-cycle commands broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } isort_cell_ctrl_t;

endpackage

>>> sv/isort_cell.sv
module isort_cell
    import isort_pkg::*;
(
    input  logic                        clk,
    input  isort_cell_ctrl_t            ctrl,
    input  logic signed [VALUE_W-1:0]   key,
    input  logic                        occupied,
    input  logic                        at_tail,
    input  logic                        left_gt,
    input  logic signed [VALUE_W-1:0]   left_value,
    input  logic signed [VALUE_W-1:0]   right_value,
    output logic signed [VALUE_W-1:0]   value,
    output logic                        gt,
    output logic                        boundary
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    assign value    = value_reg;
    // Strictly greater only: equal keys stay below the new one
    assign gt       = occupied && (value_reg > key);
    assign boundary = gt && !left_gt;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (left_gt)
                value_next = left_value;
            else if (gt || at_tail)
                value_next = key;
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

>>> sv/insertion_sort_engine.sv
// Stable insertion sorter built as a chain of cells, one element per cell.
// Input channel (value, last_element; in_valid/in_ready) takes one list element
// per beat, one beat per cycle while the list fills. All cells compare against
// the new element at once; larger ones move up a place in the same cycle.
// The beat flagged last_element ends the list. From the next cycle the chain
// drains out of cell 0 in ascending order on the output channel (sorted_value,
// end_of_list, moves_total, dropped; out_valid/out_ready), one beat per cycle
// while out_ready is high. end_of_list marks the final beat; moves_total and
// dropped are constant across the list. During the drain the chain shifts one
// cell toward cell 0 per output beat. in_ready is low during the drain.
// Elements arriving while MAX_COUNT are held are discarded and set dropped.
// A receiver stall holds the output beat and freezes the chain.
// Reset (rst_n, asynchronous, active low) empties the chain and clears the
// move count and drop flag; no clearing pass is needed.
module insertion_sort_engine
    import isort_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [VALUE_W-1:0]   value,
    input  logic                        last_element,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [VALUE_W-1:0]   sorted_value,
    output logic                        end_of_list,
    output logic [MOVES_W-1:0]          moves_total,
    output logic                        dropped
);

    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam int IW = $clog2(MAX_COUNT);

    isort_state_t      state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [MOVES_W-1:0] moves_reg, moves_next;
    logic              overflow_reg, overflow_next;

    isort_cell_ctrl_t  ctrl;
    logic              in_fire, out_fire, has_room;

    logic signed [VALUE_W-1:0] cell_value [MAX_COUNT];
    logic                      cell_gt    [MAX_COUNT];
    logic                      cell_bound [MAX_COUNT];

    logic [IW-1:0]     first_idx;
    logic              any_gt;
    logic [CW-1:0]     delta;

    assign in_ready  = (state_reg == ST_FILL);
    assign out_valid = (state_reg == ST_DRAIN);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign has_room  = (count_reg < CW'(MAX_COUNT));

    assign sorted_value = cell_value[0];
    assign end_of_list  = (count_reg == CW'(1));
    assign moves_total  = moves_reg;
    assign dropped      = overflow_reg;

    assign ctrl.insert = in_fire && has_room;
    assign ctrl.shift  = out_fire;

    genvar i;
    generate
        for (i = 0; i < MAX_COUNT; i++)
        begin : g_cell
            logic                      left_gt_w;
            logic signed [VALUE_W-1:0] left_value_w;
            logic signed [VALUE_W-1:0] right_value_w;

            if (i == 0)
            begin : g_first
                assign left_gt_w    = 1'b0;
                assign left_value_w = value;
            end
            else
            begin : g_mid
                assign left_gt_w    = cell_gt[i-1];
                assign left_value_w = cell_value[i-1];
            end

            if (i == MAX_COUNT - 1)
            begin : g_end
                assign right_value_w = cell_value[i];
            end
            else
            begin : g_inner
                assign right_value_w = cell_value[i+1];
            end

            isort_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .key         (value),
                .occupied    (CW'(i) < count_reg),
                .at_tail     (CW'(i) == count_reg),
                .left_gt     (left_gt_w),
                .left_value  (left_value_w),
                .right_value (right_value_w),
                .value       (cell_value[i]),
                .gt          (cell_gt[i]),
                .boundary    (cell_bound[i])
            );
        end
    endgenerate

    // Greater cells form one run ending at the tail; its first cell sets the move count
    always_comb
    begin
        first_idx = '0;
        any_gt    = 1'b0;
        for (int k = 0; k < MAX_COUNT; k++)
        begin
            if (cell_bound[k])
                first_idx = first_idx | IW'(k);
            any_gt = any_gt | cell_bound[k];
        end
        delta = any_gt ? (count_reg - {{(CW-IW){1'b0}}, first_idx}) : '0;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        moves_next    = moves_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CW'(1);
                        moves_next = moves_reg + MOVES_W'(delta);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last_element)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_fire)
                begin
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        moves_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            count_reg    <= '0;
            moves_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            moves_reg    <= moves_next;
            overflow_reg <= overflow_next;
        end
    end

    a_drain_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count_reg != '0))
        else $error("drain with empty chain");

    a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_element) |=> out_valid)
        else $error("last beat did not start drain");

    a_clear_after_list: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && end_of_list) |=> (in_ready && moves_reg == '0 && !overflow_reg
                                       && count_reg == '0))
        else $error("state not cleared after list");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_COUNT))
        else $error("held count beyond capacity");

endmodule
